@@ hw/rtl/mpt_pkg.sv @@
// Shared types and constants for the multi-turn position tracker.
package mpt_pkg;

   localparam int unsigned RAW_W   = 31;
   localparam int unsigned ANGLE_W = 32;
   localparam int unsigned TURN_W  = 16;
   localparam int unsigned NB_W    = 5;
   localparam int unsigned CSR_W   = 32;

   localparam logic [NB_W-1:0]   TURN_BITS_RESET = 5'd20;
   localparam logic [TURN_W-1:0] TURN_MIN        = 16'h8000;
   localparam logic [TURN_W-1:0] TURN_MAX        = 16'h7fff;

   // Quadrant codes taken from the top two bits of the normalised angle.
   localparam logic [1:0] QUAD_FIRST  = 2'b00;
   localparam logic [1:0] QUAD_FOURTH = 2'b11;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_TURN_BITS       = 1'b0,
      CSR_POSITION_OFFSET = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [RAW_W-1:0] raw_angle;
      logic             clear_status;
   } req_type;

   typedef struct packed {
      logic signed [31:0] position;
      logic signed [15:0] turn_count;
      logic signed [31:0] index_position;
      logic               origin_seen;
      logic               wrap_flag;
      logic               captured_flag;
   } rsp_type;

   // Control from the pipeline to the turn unit.
   typedef struct packed {
      logic advance;
      logic clear_status;
   } step_ctrl_type;

endpackage

@@ hw/rtl/mpt_angle_norm.sv @@
// Inverts, masks and left-aligns the raw single-turn angle.
module mpt_angle_norm (
   input  logic [mpt_pkg::RAW_W-1:0]   raw_angle,
   input  logic [mpt_pkg::NB_W-1:0]    turn_bits,
   output logic [mpt_pkg::ANGLE_W-1:0] angle
);
   import mpt_pkg::*;

   logic [NB_W-1:0] shift_amount;

   // Appending a zero and shifting by 31 - turn_bits pushes every unused raw bit out
   // of the top, so a turn_bits of zero yields a zero angle with no special case.
   assign shift_amount = NB_W'(5'd31 - turn_bits);
   assign angle        = {~raw_angle, 1'b0} << shift_amount;

endmodule

@@ hw/rtl/mpt_turn_unit.sv @@
// Revolution counter, index capture and sticky status flags.
module mpt_turn_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  mpt_pkg::step_ctrl_type      ctrl,
   input  logic [mpt_pkg::ANGLE_W-1:0] angle,
   input  logic [31:0]                 position_offset,
   output mpt_pkg::rsp_type            result
);
   import mpt_pkg::*;

   logic [1:0]        quad_ff, quad_in;
   logic [TURN_W-1:0] turn_ff, turn_in;
   logic [31:0]       index_ff, index_in;
   logic              wrap_ff, wrap_in;
   logic              capture_ff, capture_in;

   logic              neg;
   logic              dec;
   logic              inc;
   logic              origin;
   logic [TURN_W-1:0] cap_turn;

   assign neg    = angle[ANGLE_W-1];
   assign dec    = (quad_ff == QUAD_FIRST) && neg;
   assign inc    = (quad_ff == QUAD_FOURTH) && !neg;
   assign origin = dec || inc;

   always_comb begin
      turn_in = turn_ff;
      if (dec) begin
         turn_in = turn_ff - 16'd1;
      end else if (inc) begin
         turn_in = turn_ff + 16'd1;
      end
      // A decrement captures the count before the step, an increment the count after it.
      cap_turn   = dec ? turn_ff : turn_in;
      wrap_in    = (wrap_ff && !ctrl.clear_status)
                 || (dec && (turn_ff == TURN_MIN))
                 || (inc && (turn_ff == TURN_MAX));
      capture_in = (capture_ff && !ctrl.clear_status) || origin;
      index_in   = origin ? ({cap_turn, 16'h0000} + position_offset) : index_ff;
      quad_in    = angle[ANGLE_W-1:ANGLE_W-2];
   end

   always_comb begin
      result.position       = {turn_in, angle[ANGLE_W-1:ANGLE_W-16]};
      result.turn_count     = turn_in;
      result.index_position = index_in;
      result.origin_seen    = origin;
      result.wrap_flag      = wrap_in;
      result.captured_flag  = capture_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quad_ff    <= QUAD_FIRST;
         turn_ff    <= '0;
         index_ff   <= '0;
         wrap_ff    <= 1'b0;
         capture_ff <= 1'b0;
      end else if (ctrl.advance) begin
         quad_ff    <= quad_in;
         turn_ff    <= turn_in;
         index_ff   <= index_in;
         wrap_ff    <= wrap_in;
         capture_ff <= capture_in;
      end
   end

`ifndef SYNTHESIS
   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !ctrl.advance |=> $stable(turn_ff) && $stable(quad_ff) && $stable(index_ff))
      else $error("turn state changed without a transaction");

   a_origin_sets_capture: assert property (@(posedge clock) disable iff (reset)
      ctrl.advance && origin |=> capture_ff)
      else $error("crossing did not set the captured flag");

   a_no_crossing_keeps_turn: assert property (@(posedge clock) disable iff (reset)
      ctrl.advance && !origin |=> $stable(turn_ff) && $stable(index_ff))
      else $error("turn count or index moved without a crossing");

   a_increment_step: assert property (@(posedge clock) disable iff (reset)
      ctrl.advance && inc |=> turn_ff == $past(turn_ff) + 16'd1)
      else $error("increment crossing did not add one turn");
`endif

endmodule

@@ hw/rtl/multiturn_position_tracker.sv @@
// Top level of the multi-turn position tracker: channels, configuration and pipeline.
//
// Usage: each req transaction carries one raw encoder angle and a clear_status bit;
// each produces exactly one rsp transaction with the extended position, the signed
// turn count, the last captured index position and the status flags.
// Configuration registers turn_bits (index 0) and position_offset (index 1) are
// written through csr_write_enable, csr_index and csr_wdata; the user must write
// them only while no transaction is in flight, which the block does not enforce.
// A transaction accepted into the input register passes on into the result
// register and is offered on rsp from there.
// Throughput: one transaction per cycle unless rsp stalls; the turn counter update
// is a compare and increment or decrement between the input and result registers.
// Reset clears both pipeline stages, the turn state and the flags, and loads
// turn_bits with 20 and position_offset with 0.
// When the receiver stalls, the result register holds; a further transaction is
// still taken into the input register, and req_stall rises only once both
// registers are full.
module multiturn_position_tracker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  mpt_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output mpt_pkg::rsp_type          rsp_data,
   input  logic                      csr_write_enable,
   input  mpt_pkg::csr_index_type    csr_index,
   input  logic [mpt_pkg::CSR_W-1:0] csr_wdata
);
   import mpt_pkg::*;

   logic [NB_W-1:0]    turn_bits_ff;
   logic [31:0]        offset_ff;

   logic               in_valid_ff;
   req_type            in_data_ff;
   logic               out_valid_ff;
   rsp_type            out_data_ff;

   logic               out_free;
   logic               advance;
   logic [ANGLE_W-1:0] angle;
   step_ctrl_type      ctrl;
   rsp_type            result;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign ctrl.advance      = advance;
   assign ctrl.clear_status = in_data_ff.clear_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_bits_ff <= TURN_BITS_RESET;
         offset_ff    <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TURN_BITS:       turn_bits_ff <= csr_wdata[NB_W-1:0];
            CSR_POSITION_OFFSET: offset_ff    <= csr_wdata[31:0];
            default:             ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= result;
      end
   end

   mpt_angle_norm u_angle_norm (
      .raw_angle (in_data_ff.raw_angle),
      .turn_bits (turn_bits_ff),
      .angle     (angle)
   );

   mpt_turn_unit u_turn_unit (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .angle           (angle),
      .position_offset (offset_ff),
      .result          (result)
   );

endmodule
